### hw/rtl/gpt_pkg.sv
// ---------------------------------------------------------------------------
// gpt_pkg
// shared constants, types and helpers of the gait phase tracker
// ---------------------------------------------------------------------------
`default_nettype none

package gpt_pkg;

   localparam int TICK_BITS      = 16;
   localparam int FRAC_BITS      = 8;
   localparam int EST_BITS       = TICK_BITS + FRAC_BITS;
   localparam int Q16_BITS       = 16;
   localparam int FRAC_OUT_BITS  = Q16_BITS + 1;
   localparam int ALPHA_BITS     = Q16_BITS + 1;
   localparam int STEP_CNT_BITS  = $clog2(Q16_BITS);
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 17;

   localparam logic [FRAC_OUT_BITS-1:0] ONE_Q16 = FRAC_OUT_BITS'(1) << Q16_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_STRIDE     = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_STRIDE     = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EMA_ALPHA      = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOMINAL_STRIDE = CSR_INDEX_BITS'(3);

   localparam logic [TICK_BITS-1:0]  MIN_STRIDE_RESET     = TICK_BITS'(50);
   localparam logic [TICK_BITS-1:0]  MAX_STRIDE_RESET     = TICK_BITS'(300);
   localparam logic [ALPHA_BITS-1:0] EMA_ALPHA_RESET      = ALPHA_BITS'(13107);
   localparam logic [TICK_BITS-1:0]  NOMINAL_STRIDE_RESET = TICK_BITS'(110);

   typedef enum logic [1:0] {
      PH_LOADING  = 2'd0,
      PH_MID      = 2'd1,
      PH_TERMINAL = 2'd2,
      PH_SWING    = 2'd3
   } phase_type;

   function automatic phase_type decode_phase(input logic heel, input logic toe);
      phase_type ph;
      unique case ({heel, toe})
         2'b10:   ph = PH_LOADING;
         2'b11:   ph = PH_MID;
         2'b01:   ph = PH_TERMINAL;
         default: ph = PH_SWING;
      endcase
      return ph;
   endfunction

   function automatic logic [TICK_BITS-1:0] sat_inc(input logic [TICK_BITS-1:0] v);
      return (&v) ? v : v + TICK_BITS'(1);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/gpt_ema_mul.sv
// ---------------------------------------------------------------------------
// gpt_ema_mul
// bit-serial moving average update of the stride estimate
// ---------------------------------------------------------------------------
`default_nettype none

module gpt_ema_mul
   import gpt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [Q16_BITS-1:0] alpha,
   input  wire logic [EST_BITS-1:0] est_old,
   input  wire logic [EST_BITS-1:0] target,
   output logic                     done,
   output logic [EST_BITS-1:0]      est_new
);

   localparam int ACC_BITS = EST_BITS + Q16_BITS;
   localparam logic [ACC_BITS-1:0] RND_UP   = ACC_BITS'(1) << (Q16_BITS - 1);
   localparam logic [ACC_BITS-1:0] RND_DOWN = RND_UP - ACC_BITS'(1);

   logic                     busy_ff;
   logic                     done_ff;
   logic                     up_ff;
   logic [STEP_CNT_BITS-1:0] cnt_ff;
   logic [Q16_BITS-1:0]      alpha_ff;
   logic [EST_BITS-1:0]      diff_ff;
   logic [EST_BITS-1:0]      est_ff;
   logic [ACC_BITS-1:0]      acc_ff;
   logic [ACC_BITS-1:0]      acc_in;
   logic [ACC_BITS-1:0]      rounded;
   logic [EST_BITS-1:0]      adj;

   // shift-add, alpha msb first
   assign acc_in = {acc_ff[ACC_BITS-2:0], 1'b0}
                 + (alpha_ff[Q16_BITS-1] ? {{Q16_BITS{1'b0}}, diff_ff} : '0);

   assign rounded = acc_ff + (up_ff ? RND_UP : RND_DOWN);
   assign adj     = rounded[ACC_BITS-1:Q16_BITS];
   assign est_new = up_ff ? est_ff + adj : est_ff - adj;
   assign done    = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            cnt_ff   <= '0;
            up_ff    <= (target >= est_old);
            diff_ff  <= (target >= est_old) ? target - est_old : est_old - target;
            est_ff   <= est_old;
            alpha_ff <= alpha;
            acc_ff   <= '0;
         end else if (busy_ff) begin
            acc_ff   <= acc_in;
            alpha_ff <= {alpha_ff[Q16_BITS-2:0], 1'b0};
            cnt_ff   <= cnt_ff + STEP_CNT_BITS'(1);
            if (&cnt_ff) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/gpt_frac_div.sv
// ---------------------------------------------------------------------------
// gpt_frac_div
// restoring serial divider for the stride fraction, one quotient bit a cycle
// ---------------------------------------------------------------------------
`default_nettype none

module gpt_frac_div
   import gpt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [EST_BITS-1:0] dividend,
   input  wire logic [EST_BITS-1:0] divisor,
   output logic                     done,
   output logic [Q16_BITS-1:0]      quot
);

   logic                     busy_ff;
   logic                     done_ff;
   logic [STEP_CNT_BITS-1:0] cnt_ff;
   logic [EST_BITS-1:0]      rem_ff;
   logic [EST_BITS-1:0]      div_ff;
   logic [Q16_BITS-1:0]      quot_ff;
   logic [EST_BITS:0]        shifted;
   logic                     fits;

   // remainder stays below the divisor, so one compare-subtract per bit
   assign shifted = {rem_ff, 1'b0};
   assign fits    = (shifted >= {1'b0, div_ff});
   assign done    = done_ff;
   assign quot    = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= dividend;
            div_ff  <= divisor;
            quot_ff <= '0;
         end else if (busy_ff) begin
            rem_ff  <= fits ? EST_BITS'(shifted - {1'b0, div_ff}) : shifted[EST_BITS-1:0];
            quot_ff <= {quot_ff[Q16_BITS-2:0], fits};
            cnt_ff  <= cnt_ff + STEP_CNT_BITS'(1);
            if (&cnt_ff) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/gait_phase_tracker.sv
// ---------------------------------------------------------------------------
// gait_phase_tracker
// gait phase decoder with stride timing, moving average and stride fraction
// ---------------------------------------------------------------------------
// one req_ transfer is one control tick with the heel and toe contact bits;
// each tick gives exactly one rsp_ transfer with phase, event pulses, sync,
// stride fraction, stride estimate and the two saturating tick timers.
// csr_ writes set the stride limits, the average weight and the nominal
// stride; csr_ready is always high, indexes beyond the list are dropped.
// a tick is taken only while the block is idle; the next tick can be taken
// while the previous result still sits in the output register.
// a tick goes from idle through S_EMA when a heel strike updates the average
// (bit-serial multiplier), then S_FRAC, S_DIV when the fraction needs the
// bit-serial divider, and S_OUT, which loads the output register.
// when rsp_ready is low a finished result waits in the output register and
// the block holds its work until that register frees up.
// synchronous reset returns the registers to defaults and the tracker to
// its unprimed state; the first tick only adopts the phase and estimate.
// ---------------------------------------------------------------------------
`default_nettype none

module gait_phase_tracker
   import gpt_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_heel_contact,
   input  wire logic                      req_toe_contact,

   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [1:0]                     rsp_gait_phase_code,
   output logic                           rsp_heel_strike,
   output logic                           rsp_toe_off,
   output logic                           rsp_sync_ok,
   output logic [FRAC_OUT_BITS-1:0]       rsp_stride_fraction,
   output logic [EST_BITS-1:0]            rsp_stride_estimate_out,
   output logic [TICK_BITS-1:0]           rsp_idle_ticks,
   output logic [TICK_BITS-1:0]           rsp_swing_ticks,

   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EMA,
      S_FRAC,
      S_DIV,
      S_OUT
   } state_type;

   state_type                state_ff;

   logic [TICK_BITS-1:0]     min_stride_ff;
   logic [TICK_BITS-1:0]     max_stride_ff;
   logic [ALPHA_BITS-1:0]    alpha_ff;
   logic [TICK_BITS-1:0]     nominal_ff;

   logic                     primed_ff;
   phase_type                phase_ff;
   logic                     sync_ff;
   logic [EST_BITS-1:0]      est_ff;
   logic [TICK_BITS-1:0]     stride_ff;
   logic [TICK_BITS-1:0]     event_age_ff;
   logic [TICK_BITS-1:0]     swing_age_ff;
   logic                     hs_ff;
   logic                     to_ff;
   logic [FRAC_OUT_BITS-1:0] frac_ff;

   logic                     rsp_valid_ff;
   logic [1:0]               rsp_phase_ff;
   logic                     rsp_hs_ff;
   logic                     rsp_to_ff;
   logic                     rsp_sync_ff;
   logic [FRAC_OUT_BITS-1:0] rsp_frac_ff;
   logic [EST_BITS-1:0]      rsp_est_ff;
   logic [TICK_BITS-1:0]     rsp_idle_ff;
   logic [TICK_BITS-1:0]     rsp_swing_ff;

   phase_type                next_phase;
   logic                     accept;
   logic                     hs_in;
   logic                     to_in;
   logic                     in_range;
   logic [EST_BITS-1:0]      stride_fix;
   logic                     ema_start;
   logic                     ema_done;
   logic [EST_BITS-1:0]      ema_est_new;
   logic                     div_start;
   logic                     div_done;
   logic [Q16_BITS-1:0]      div_quot;

   assign req_ready  = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign accept     = req_valid && req_ready;
   assign next_phase = decode_phase(req_heel_contact, req_toe_contact);
   assign stride_fix = {stride_ff, {FRAC_BITS{1'b0}}};

   assign hs_in = primed_ff && (phase_ff == PH_SWING)
               && (next_phase == PH_LOADING || next_phase == PH_MID);
   assign to_in = primed_ff && (phase_ff != PH_SWING) && (next_phase == PH_SWING);

   assign in_range  = (stride_ff >= min_stride_ff) && (stride_ff <= max_stride_ff);
   assign ema_start = accept && hs_in && in_range && !alpha_ff[Q16_BITS];
   assign div_start = (state_ff == S_FRAC) && (stride_ff != '0) && (stride_fix < est_ff);

   gpt_ema_mul u_ema (
      .clock   (clock),
      .reset   (reset),
      .start   (ema_start),
      .alpha   (alpha_ff[Q16_BITS-1:0]),
      .est_old (est_ff),
      .target  (stride_fix),
      .done    (ema_done),
      .est_new (ema_est_new)
   );

   gpt_frac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (stride_fix),
      .divisor  (est_ff),
      .done     (div_done),
      .quot     (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         min_stride_ff <= MIN_STRIDE_RESET;
         max_stride_ff <= MAX_STRIDE_RESET;
         alpha_ff      <= EMA_ALPHA_RESET;
         nominal_ff    <= NOMINAL_STRIDE_RESET;
         primed_ff     <= 1'b0;
         phase_ff      <= PH_MID;
         sync_ff       <= 1'b0;
         est_ff        <= '0;
         stride_ff     <= '0;
         event_age_ff  <= '0;
         swing_age_ff  <= '0;
         hs_ff         <= 1'b0;
         to_ff         <= 1'b0;
         frac_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MIN_STRIDE:     min_stride_ff <= csr_wdata[TICK_BITS-1:0];
               CSR_MAX_STRIDE:     max_stride_ff <= csr_wdata[TICK_BITS-1:0];
               CSR_EMA_ALPHA:      alpha_ff      <= csr_wdata[ALPHA_BITS-1:0];
               CSR_NOMINAL_STRIDE: nominal_ff    <= csr_wdata[TICK_BITS-1:0];
               default: ;
            endcase
         end

         // a result loaded in S_OUT replaces the one leaving
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  hs_ff    <= hs_in;
                  to_ff    <= to_in;
                  phase_ff <= next_phase;
                  state_ff <= ema_start ? S_EMA : S_FRAC;
                  if (!primed_ff) begin
                     primed_ff <= 1'b1;
                     est_ff    <= {nominal_ff, {FRAC_BITS{1'b0}}};
                  end else begin
                     if (hs_in) begin
                        sync_ff <= 1'b1;
                     end else if (phase_ff == PH_SWING && next_phase == PH_TERMINAL) begin
                        sync_ff <= 1'b0;
                     end
                     if (hs_in && in_range && alpha_ff[Q16_BITS]) begin
                        est_ff <= stride_fix;
                     end
                     stride_ff    <= hs_in ? TICK_BITS'(1) : sat_inc(stride_ff);
                     event_age_ff <= (hs_in || to_in) ? '0 : sat_inc(event_age_ff);
                     swing_age_ff <= to_in ? TICK_BITS'(1) : sat_inc(swing_age_ff);
                  end
               end
            end
            S_EMA: begin
               if (ema_done) begin
                  est_ff   <= ema_est_new;
                  state_ff <= S_FRAC;
               end
            end
            S_FRAC: begin
               if (stride_ff == '0) begin
                  frac_ff  <= '0;
                  state_ff <= S_OUT;
               end else if (stride_fix >= est_ff) begin
                  frac_ff  <= ONE_Q16;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  frac_ff  <= {1'b0, div_quot};
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_phase_ff <= phase_ff;
                  rsp_hs_ff    <= hs_ff;
                  rsp_to_ff    <= to_ff;
                  rsp_sync_ff  <= sync_ff;
                  rsp_frac_ff  <= frac_ff;
                  rsp_est_ff   <= est_ff;
                  rsp_idle_ff  <= event_age_ff;
                  rsp_swing_ff <= swing_age_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_gait_phase_code     = rsp_phase_ff;
   assign rsp_heel_strike         = rsp_hs_ff;
   assign rsp_toe_off             = rsp_to_ff;
   assign rsp_sync_ok             = rsp_sync_ff;
   assign rsp_stride_fraction     = rsp_frac_ff;
   assign rsp_stride_estimate_out = rsp_est_ff;
   assign rsp_idle_ticks          = rsp_idle_ff;
   assign rsp_swing_ticks         = rsp_swing_ff;

   a_events_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_heel_strike && rsp_toe_off))
      else $error("heel strike and toe off in one transfer");

   a_strike_syncs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_heel_strike |-> rsp_sync_ok)
      else $error("heel strike without sync");

   a_fraction_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stride_fraction[Q16_BITS] |-> rsp_stride_fraction[Q16_BITS-1:0] == '0)
      else $error("stride fraction above one");

   a_toe_off_timers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_toe_off |-> rsp_idle_ticks == '0 && rsp_swing_ticks == TICK_BITS'(1))
      else $error("timers not restarted on toe off");

endmodule

`default_nettype wire

### test/gpt_checker.sv
// ---------------------------------------------------------------------------
// gpt_checker
// gait tracker predictor and result comparison
// ---------------------------------------------------------------------------
// watches the tick, result and register channels of the gait phase tracker,
// keeps its own copy of the tracker state and registers, predicts one result
// per accepted tick and compares each result transfer field by field with the
// oldest prediction. mismatches and unexpected results are counted as
// failures and handed to the testbench top with the number still awaited.
// ---------------------------------------------------------------------------

module gpt_checker
   import gpt_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_ready,
   input  wire logic                      req_heel_contact,
   input  wire logic                      req_toe_contact,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire logic [1:0]                rsp_gait_phase_code,
   input  wire logic                      rsp_heel_strike,
   input  wire logic                      rsp_toe_off,
   input  wire logic                      rsp_sync_ok,
   input  wire logic [FRAC_OUT_BITS-1:0]  rsp_stride_fraction,
   input  wire logic [EST_BITS-1:0]       rsp_stride_estimate_out,
   input  wire logic [TICK_BITS-1:0]      rsp_idle_ticks,
   input  wire logic [TICK_BITS-1:0]      rsp_swing_ticks,
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                             failures,
   output int                             pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      phase_type                phase;
      logic                     heel_strike;
      logic                     toe_off;
      logic                     sync_ok;
      logic [FRAC_OUT_BITS-1:0] fraction;
      logic [EST_BITS-1:0]      estimate;
      logic [TICK_BITS-1:0]     idle_ticks;
      logic [TICK_BITS-1:0]     swing_ticks;
   } tick_result_t;

   logic [TICK_BITS-1:0]  min_stride;
   logic [TICK_BITS-1:0]  max_stride;
   logic [ALPHA_BITS-1:0] alpha;
   logic [TICK_BITS-1:0]  nominal_stride;

   logic                  primed;
   phase_type             phase_q;
   logic                  sync_q;
   logic [EST_BITS-1:0]   estimate_q;
   logic [TICK_BITS-1:0]  stride_cnt;
   logic [TICK_BITS-1:0]  event_age;
   logic [TICK_BITS-1:0]  swing_age;

   tick_result_t          expected_ticks [$];
   int                    fail_count = 0;

   function automatic logic [TICK_BITS-1:0] bump(input logic [TICK_BITS-1:0] v);
      return (v == {TICK_BITS{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic string describe(input tick_result_t r);
      return $sformatf("phase %0d hs %0b to %0b sync %0b frac %0d est %0d idle %0d swing %0d",
                       r.phase, r.heel_strike, r.toe_off, r.sync_ok, r.fraction,
                       r.estimate, r.idle_ticks, r.swing_ticks);
   endfunction

   function automatic tick_result_t track_tick(input logic heel, input logic toe);
      phase_type    nxt;
      logic         strike;
      logic         lift;
      logic [63:0]  w;
      logic [63:0]  x;
      logic [63:0]  e;
      logic [63:0]  t;
      tick_result_t r;
      strike = 1'b0;
      lift   = 1'b0;
      case ({heel, toe})
         2'b10:   nxt = PH_LOADING;
         2'b11:   nxt = PH_MID;
         2'b01:   nxt = PH_TERMINAL;
         default: nxt = PH_SWING;
      endcase
      if (!primed) begin
         primed     = 1'b1;
         phase_q    = nxt;
         estimate_q = {nominal_stride, {FRAC_BITS{1'b0}}};
      end else begin
         if (phase_q == PH_SWING && nxt != PH_SWING) begin
            if (nxt == PH_TERMINAL) begin
               sync_q = 1'b0;
            end else begin
               strike = 1'b1;
               sync_q = 1'b1;
               if (stride_cnt >= min_stride && stride_cnt <= max_stride) begin
                  w = (alpha > ONE_Q16) ? 64'(ONE_Q16) : 64'(alpha);
                  x = 64'(stride_cnt) << FRAC_BITS;
                  e = 64'(estimate_q);
                  if (w == 64'(ONE_Q16)) begin
                     e = x;
                  end else if (x >= e) begin
                     e = e + ((w * (x - e) + 64'd32768) >> 16);
                  end else begin
                     e = e - ((w * (e - x) + 64'd32767) >> 16);
                  end
                  estimate_q = e[EST_BITS-1:0];
               end
               stride_cnt = '0;
            end
         end else if (phase_q != PH_SWING && nxt == PH_SWING) begin
            lift = 1'b1;
         end
         phase_q    = nxt;
         event_age  = (strike || lift) ? '0 : bump(event_age);
         swing_age  = bump(lift ? '0 : swing_age);
         stride_cnt = bump(stride_cnt);
      end
      t = 64'(stride_cnt) << FRAC_BITS;
      r.phase       = phase_q;
      r.heel_strike = strike;
      r.toe_off     = lift;
      r.sync_ok     = sync_q;
      if (stride_cnt == '0) begin
         r.fraction = '0;
      end else if (t >= 64'(estimate_q)) begin
         r.fraction = ONE_Q16;
      end else begin
         r.fraction = FRAC_OUT_BITS'((t << 16) / 64'(estimate_q));
      end
      r.estimate    = estimate_q;
      r.idle_ticks  = event_age;
      r.swing_ticks = swing_age;
      return r;
   endfunction

   always @(posedge clock) begin
      tick_result_t want;
      tick_result_t got;
      if (reset) begin
         min_stride     = MIN_STRIDE_RESET;
         max_stride     = MAX_STRIDE_RESET;
         alpha          = EMA_ALPHA_RESET;
         nominal_stride = NOMINAL_STRIDE_RESET;
         primed         = 1'b0;
         phase_q        = PH_MID;
         sync_q         = 1'b0;
         estimate_q     = '0;
         stride_cnt     = '0;
         event_age      = '0;
         swing_age      = '0;
         expected_ticks.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.phase       = phase_type'(rsp_gait_phase_code);
            got.heel_strike = rsp_heel_strike;
            got.toe_off     = rsp_toe_off;
            got.sync_ok     = rsp_sync_ok;
            got.fraction    = rsp_stride_fraction;
            got.estimate    = rsp_stride_estimate_out;
            got.idle_ticks  = rsp_idle_ticks;
            got.swing_ticks = rsp_swing_ticks;
            if (expected_ticks.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: unexpected result transfer: %s", $realtime, describe(got));
               end
            end else begin
               want = expected_ticks.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(got));
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_STRIDE:     min_stride     = csr_wdata[TICK_BITS-1:0];
               CSR_MAX_STRIDE:     max_stride     = csr_wdata[TICK_BITS-1:0];
               CSR_EMA_ALPHA:      alpha          = csr_wdata[ALPHA_BITS-1:0];
               CSR_NOMINAL_STRIDE: nominal_stride = csr_wdata[TICK_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_ticks.push_back(track_tick(req_heel_contact, req_toe_contact));
         end
      end
      pending_results <= expected_ticks.size();
      failures        <= fail_count;
   end

endmodule

### test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// testbench for the gait phase tracker
// ---------------------------------------------------------------------------
// drives control ticks as heel and toe contact bits: a short directed walk
// through every phase, the first tick, a zero stride estimate and
// crossed stride limits, then random gait cycles with broken sequences and
// noise under several register settings. the sender idles in bursts and the
// receiver stalls on a pattern of its own; gpt_checker predicts and compares.
// ---------------------------------------------------------------------------

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gpt_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int INDEX_TOP    = (1 << CSR_INDEX_BITS) - 1;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_heel_contact;
   logic                      req_toe_contact;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_gait_phase_code;
   logic                      rsp_heel_strike;
   logic                      rsp_toe_off;
   logic                      rsp_sync_ok;
   logic [FRAC_OUT_BITS-1:0]  rsp_stride_fraction;
   logic [EST_BITS-1:0]       rsp_stride_estimate_out;
   logic [TICK_BITS-1:0]      rsp_idle_ticks;
   logic [TICK_BITS-1:0]      rsp_swing_ticks;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   int                        failures;
   int                        pending_results;

   int                        cycle_count = 0;
   int                        burst_left  = 0;
   int                        ticks_sent  = 0;
   logic [15:0]               ready_mask  = 16'hFFFF;
   int                        ready_hold  = 0;

   phase_type opening_walk [13] = '{PH_SWING, PH_SWING, PH_LOADING, PH_MID, PH_TERMINAL,
                                    PH_SWING, PH_TERMINAL, PH_SWING, PH_MID, PH_LOADING,
                                    PH_SWING, PH_SWING, PH_LOADING};
   phase_type crossed_walk [4]  = '{PH_SWING, PH_MID, PH_SWING, PH_LOADING};

   gait_phase_tracker DUT (.*);

   gpt_checker tracker_check (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver stall pattern, reloaded when its random hold count runs out
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_hold <= $urandom_range(8, 64);
         ready_mask <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      end else begin
         ready_hold <= ready_hold - 1;
      end
      rsp_ready <= ready_mask[ready_hold[3:0]];
   end

   function automatic logic [1:0] contacts_of(input phase_type ph);
      case (ph)
         PH_LOADING:  return 2'b10;
         PH_MID:      return 2'b11;
         PH_TERMINAL: return 2'b01;
         default:     return 2'b00;
      endcase
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // bit 16 of the tick registers is random and must be dropped by the block
   task automatic apply_setting(input logic [TICK_BITS-1:0] lo, input logic [TICK_BITS-1:0] hi,
                                input logic [ALPHA_BITS-1:0] w,
                                input logic [TICK_BITS-1:0] nom);
      csr_write(CSR_MIN_STRIDE, {1'($urandom_range(0, 1)), lo});
      csr_write(CSR_MAX_STRIDE, {1'($urandom_range(0, 1)), hi});
      csr_write(CSR_EMA_ALPHA, w);
      csr_write(CSR_NOMINAL_STRIDE, {1'($urandom_range(0, 1)), nom});
      csr_write(CSR_INDEX_BITS'($urandom_range(CSR_NOMINAL_STRIDE + 1, INDEX_TOP)),
                CSR_DATA_BITS'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic issue(input logic [1:0] contacts);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid        <= 1'b1;
      req_heel_contact <= contacts[1];
      req_toe_contact  <= contacts[0];
      do @(posedge clock); while (!req_ready);
      burst_left--;
      ticks_sent++;
   endtask

   task automatic drain();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   // mostly whole gait cycles, some swing to terminal breaks, some noise
   task automatic walk(input int n_ticks, input int dmax);
      int start;
      int pick;
      start = ticks_sent;
      while (ticks_sent - start < n_ticks) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            if ($urandom_range(0, 3) != 0) begin
               repeat ($urandom_range(1, dmax)) issue(contacts_of(PH_LOADING));
            end
            repeat ($urandom_range(1, dmax)) issue(contacts_of(PH_MID));
            repeat ($urandom_range(1, dmax)) issue(contacts_of(PH_TERMINAL));
            repeat ($urandom_range(1, dmax)) issue(contacts_of(PH_SWING));
         end else if (pick < 9) begin
            repeat ($urandom_range(1, dmax)) issue(contacts_of(PH_TERMINAL));
            repeat ($urandom_range(1, dmax)) issue(contacts_of(PH_SWING));
            repeat ($urandom_range(1, dmax)) issue(contacts_of(PH_TERMINAL));
         end else begin
            repeat ($urandom_range(1, 6)) issue(2'($urandom_range(0, 3)));
         end
      end
   endtask

   initial begin
      int                    dmax;
      logic [TICK_BITS-1:0]  lo;
      logic [TICK_BITS-1:0]  hi;
      logic [ALPHA_BITS-1:0] w;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_heel_contact <= 1'b0;
      req_toe_contact  <= 1'b0;
      csr_valid        <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // zero nominal stride, widest limits, weight above one
      apply_setting(TICK_BITS'(1), '1, '1, '0);
      foreach (opening_walk[i]) issue(contacts_of(opening_walk[i]));
      drain();

      // minimum above maximum, zero weight, late nominal write
      apply_setting(TICK_BITS'(200), TICK_BITS'(100), '0, '1);
      foreach (crossed_walk[i]) issue(contacts_of(crossed_walk[i]));
      drain();

      for (int k = 0; k < 5; k++) begin
         dmax = $urandom_range(2, 12);
         case (k)
            0: begin
               lo = TICK_BITS'(1);
               hi = '1;
               w  = ONE_Q16;
            end
            1: begin
               lo = '1;
               hi = TICK_BITS'(1);
               w  = ALPHA_BITS'(1);
            end
            2: begin
               lo = TICK_BITS'($urandom_range(1, 2 * dmax + 2));
               hi = lo + TICK_BITS'($urandom_range(0, 3 * dmax));
               w  = '0;
            end
            default: begin
               lo = TICK_BITS'($urandom_range(1, 2 * dmax + 2));
               hi = lo + TICK_BITS'($urandom_range(0, 3 * dmax));
               w  = ALPHA_BITS'($urandom);
            end
         endcase
         apply_setting(lo, hi, w, TICK_BITS'($urandom));
         walk(100, dmax);
         drain();
      end

      repeat (64) @(posedge clock);
      if (failures == 0 && pending_results == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
